// ===== hdl/otp_pkg.sv =====
// otp_pkg: shared types, codes and sizes of the one-shot timer pool
// used by otp_front, otp_cmd_fifo, otp_back and one_shot_timer_pool
// no dependencies
package otp_pkg;

  localparam int NUM_TIMERS  = 8;
  // slot index and slot field are three bits wide, so at most eight slots exist
  localparam int SLOT_W      = 3;
  localparam int SLOT_CAP    = 1 << SLOT_W;
  localparam int POOL_SLOTS  = (NUM_TIMERS < SLOT_CAP) ? NUM_TIMERS : SLOT_CAP;
  localparam int TICK_W      = 32;
  localparam int TAG_W       = 32;
  localparam int FUNC_W      = 3;
  localparam int STATUS_W    = 3;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);

  // function codes as they arrive on the input channel
  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FN_ALLOC = 3'd0;
  localparam func_t FN_FREE  = 3'd1;
  localparam func_t FN_SET   = 3'd2;
  localparam func_t FN_TAG   = 3'd3;
  localparam func_t FN_TICK  = 3'd4;

  // result status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STS_OK        = 3'd0;
  localparam status_t STS_NO_FREE   = 3'd1;
  localparam status_t STS_BAD       = 3'd2;
  localparam status_t STS_EXPIRED   = 3'd3;
  localparam status_t STS_NO_EXPIRY = 3'd4;

  // slot life cycle, encoded as one bit per busy state
  typedef enum logic [1:0] {
    SL_FREE  = 2'd0,
    SL_ALLOC = 2'd1,
    SL_COUNT = 2'd2
  } slot_st_t;

  // decoded operation handed from front to back
  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_START,
    OP_STOP,
    OP_TAG,
    OP_TICK,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               idx_ok;
    logic [SLOT_W-1:0]  idx;
    logic [TICK_W-1:0]  count;
    logic [TAG_W-1:0]   tag;
    logic               notify;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [TAG_W-1:0]   tag;
    logic               last;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FINISH
  } back_st_t;

endpackage

// ===== hdl/otp_front.sv =====
// otp_front: decodes one input item into a command for the back end
// depends on otp_pkg
module otp_front (
  input  logic [otp_pkg::FUNC_W-1:0]     func,
  input  logic [otp_pkg::IN_TDATA_W-1:0] tdata,
  output otp_pkg::cmd_t                  cmd
);

  logic [otp_pkg::SLOT_W:0] idx_ext;
  logic [otp_pkg::SLOT_W:0] pool_lim;
  logic [otp_pkg::TICK_W-1:0] count;

  assign idx_ext  = {1'b0, tdata[otp_pkg::SLOT_W-1:0]};
  assign pool_lim = (otp_pkg::SLOT_W+1)'(otp_pkg::POOL_SLOTS);
  assign count    = tdata[34:3];

  always_comb begin
    cmd.idx    = tdata[otp_pkg::SLOT_W-1:0];
    cmd.count  = count;
    cmd.tag    = tdata[66:35];
    cmd.notify = tdata[67];
    cmd.idx_ok = idx_ext < pool_lim;
    unique case (func)
      otp_pkg::FN_ALLOC: cmd.op = otp_pkg::OP_ALLOC;
      otp_pkg::FN_FREE:  cmd.op = otp_pkg::OP_FREE;
      otp_pkg::FN_SET:   cmd.op = (count == '0) ? otp_pkg::OP_STOP : otp_pkg::OP_START;
      otp_pkg::FN_TAG:   cmd.op = otp_pkg::OP_TAG;
      otp_pkg::FN_TICK:  cmd.op = otp_pkg::OP_TICK;
      default:           cmd.op = otp_pkg::OP_BAD;
    endcase
  end

endmodule

// ===== hdl/otp_cmd_fifo.sv =====
// otp_cmd_fifo: short command queue between front and back
// depends on otp_pkg
module otp_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  otp_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output otp_pkg::cmd_t pop_data,
  output logic          empty
);

  otp_pkg::cmd_t                mem_r [otp_pkg::Q_DEPTH];
  logic [otp_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [otp_pkg::Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [otp_pkg::Q_PTR_W:0]    fill_r, fill_nxt;

  assign full     = fill_r == (otp_pkg::Q_PTR_W+1)'(otp_pkg::Q_DEPTH);
  assign empty    = fill_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == otp_pkg::Q_PTR_W'(otp_pkg::Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == otp_pkg::Q_PTR_W'(otp_pkg::Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) (full && !pop) |=> !empty)
    else $error("queue lost entries while full");
  assert property (@(posedge clk) disable iff (!rst_n) (push && !pop) |=> !empty)
    else $error("queue empty after a push");
  assert property (@(posedge clk) disable iff (!rst_n) !(full && empty))
    else $error("queue full and empty at once");

endmodule

// ===== hdl/otp_back.sv =====
// otp_back: executes commands on the slot table and drives the result register
// depends on otp_pkg
module otp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  otp_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output logic          res_valid,
  output otp_pkg::res_t res,
  input  logic          res_ready
);

  otp_pkg::slot_st_t           slot_st_r  [otp_pkg::SLOT_CAP];
  otp_pkg::slot_st_t           slot_st_nxt[otp_pkg::SLOT_CAP];
  logic [otp_pkg::TICK_W-1:0]  ticks_r    [otp_pkg::SLOT_CAP];
  logic [otp_pkg::TICK_W-1:0]  ticks_nxt  [otp_pkg::SLOT_CAP];
  logic [otp_pkg::TAG_W-1:0]   tag_r      [otp_pkg::SLOT_CAP];
  logic [otp_pkg::TAG_W-1:0]   tag_nxt    [otp_pkg::SLOT_CAP];
  logic                        notify_r   [otp_pkg::SLOT_CAP];
  logic                        notify_nxt [otp_pkg::SLOT_CAP];

  otp_pkg::back_st_t           state_r, state_nxt;
  logic [otp_pkg::SLOT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic                        pend_valid_r, pend_valid_nxt;
  logic [otp_pkg::SLOT_W-1:0]  pend_slot_r, pend_slot_nxt;
  logic [otp_pkg::TAG_W-1:0]   pend_tag_r, pend_tag_nxt;
  logic                        res_valid_r, res_valid_nxt;
  otp_pkg::res_t               res_r, res_nxt;

  logic                        res_free;
  logic                        free_found;
  logic [otp_pkg::SLOT_W-1:0]  free_idx;
  otp_pkg::slot_st_t           cmd_st;
  logic                        scan_cnt;
  logic [otp_pkg::TICK_W-1:0]  scan_dec;
  logic                        scan_fire;
  logic                        scan_end;

  assign res_valid = res_valid_r;
  assign res       = res_r;
  // the result register can take a new item this cycle
  assign res_free  = !res_valid_r || res_ready;

  assign cmd_st    = slot_st_r[cmd.idx];

  // one slot per cycle during a tick scan, unless a second expiry waits on a full result register
  assign scan_cnt  = slot_st_r[scan_idx_r] == otp_pkg::SL_COUNT;
  assign scan_dec  = (ticks_r[scan_idx_r] != '0) ? ticks_r[scan_idx_r] - 1'b1
                                                 : ticks_r[scan_idx_r];
  assign scan_fire = scan_cnt && (scan_dec == '0) && notify_r[scan_idx_r];
  assign scan_end  = scan_idx_r == otp_pkg::SLOT_W'(otp_pkg::POOL_SLOTS-1);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = otp_pkg::POOL_SLOTS-1; i >= 0; i--) begin
      if (slot_st_r[i] == otp_pkg::SL_FREE) begin
        free_found = 1'b1;
        free_idx   = otp_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    slot_st_nxt    = slot_st_r;
    ticks_nxt      = ticks_r;
    tag_nxt        = tag_r;
    notify_nxt     = notify_r;
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_slot_nxt  = pend_slot_r;
    pend_tag_nxt   = pend_tag_r;
    res_nxt        = res_r;
    res_valid_nxt  = res_valid_r && !res_ready;
    cmd_pop        = 1'b0;

    unique case (state_r)
      otp_pkg::BK_IDLE: begin
        if (!cmd_empty && res_free) begin
          cmd_pop       = 1'b1;
          res_valid_nxt = 1'b1;
          res_nxt.tag   = '0;
          res_nxt.last  = 1'b1;
          res_nxt.slot  = cmd.idx;
          res_nxt.status = otp_pkg::STS_OK;
          unique case (cmd.op)
            otp_pkg::OP_ALLOC: begin
              if (free_found) begin
                slot_st_nxt[free_idx] = otp_pkg::SL_ALLOC;
                notify_nxt[free_idx]  = cmd.notify;
                res_nxt.slot          = free_idx;
              end else begin
                res_nxt.status = otp_pkg::STS_NO_FREE;
                res_nxt.slot   = '0;
              end
            end
            otp_pkg::OP_FREE: begin
              if (!cmd.idx_ok) begin
                res_nxt.status = otp_pkg::STS_BAD;
              end else begin
                slot_st_nxt[cmd.idx] = otp_pkg::SL_FREE;
                ticks_nxt[cmd.idx]   = '0;
                tag_nxt[cmd.idx]     = '0;
                notify_nxt[cmd.idx]  = 1'b0;
              end
            end
            otp_pkg::OP_START: begin
              if (!cmd.idx_ok || cmd_st != otp_pkg::SL_ALLOC) begin
                res_nxt.status = otp_pkg::STS_BAD;
              end else begin
                slot_st_nxt[cmd.idx] = otp_pkg::SL_COUNT;
                ticks_nxt[cmd.idx]   = cmd.count;
              end
            end
            otp_pkg::OP_STOP: begin
              if (!cmd.idx_ok || cmd_st == otp_pkg::SL_FREE) begin
                res_nxt.status = otp_pkg::STS_BAD;
              end else begin
                slot_st_nxt[cmd.idx] = otp_pkg::SL_ALLOC;
                ticks_nxt[cmd.idx]   = '0;
              end
            end
            otp_pkg::OP_TAG: begin
              if (!cmd.idx_ok || cmd_st != otp_pkg::SL_ALLOC) begin
                res_nxt.status = otp_pkg::STS_BAD;
              end else begin
                tag_nxt[cmd.idx] = cmd.tag;
              end
            end
            otp_pkg::OP_TICK: begin
              // results of a tick come out of the scan
              res_valid_nxt  = res_valid_r && !res_ready;
              res_nxt        = res_r;
              state_nxt      = otp_pkg::BK_SCAN;
              scan_idx_nxt   = '0;
              pend_valid_nxt = 1'b0;
            end
            default: begin
              res_nxt.status = otp_pkg::STS_BAD;
              res_nxt.slot   = '0;
            end
          endcase
        end
      end

      otp_pkg::BK_SCAN: begin
        // a second expiry must push the held one out first
        if (!(scan_fire && pend_valid_r && !res_free)) begin
          if (scan_cnt) begin
            ticks_nxt[scan_idx_r] = scan_dec;
          end
          if (scan_fire) begin
            slot_st_nxt[scan_idx_r] = otp_pkg::SL_FREE;
            ticks_nxt[scan_idx_r]   = '0;
            tag_nxt[scan_idx_r]     = '0;
            notify_nxt[scan_idx_r]  = 1'b0;
            if (pend_valid_r) begin
              res_valid_nxt  = 1'b1;
              res_nxt.status = otp_pkg::STS_EXPIRED;
              res_nxt.slot   = pend_slot_r;
              res_nxt.tag    = pend_tag_r;
              res_nxt.last   = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_slot_nxt  = scan_idx_r;
            pend_tag_nxt   = tag_r[scan_idx_r];
          end
          if (scan_end) begin
            state_nxt = otp_pkg::BK_FINISH;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
      end

      otp_pkg::BK_FINISH: begin
        if (res_free) begin
          res_valid_nxt  = 1'b1;
          res_nxt.last   = 1'b1;
          if (pend_valid_r) begin
            res_nxt.status = otp_pkg::STS_EXPIRED;
            res_nxt.slot   = pend_slot_r;
            res_nxt.tag    = pend_tag_r;
          end else begin
            res_nxt.status = otp_pkg::STS_NO_EXPIRY;
            res_nxt.slot   = '0;
            res_nxt.tag    = '0;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = otp_pkg::BK_IDLE;
        end
      end

      default: begin
        state_nxt = otp_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < otp_pkg::SLOT_CAP; i++) begin
        slot_st_r[i] <= otp_pkg::SL_FREE;
        ticks_r[i]   <= '0;
        tag_r[i]     <= '0;
        notify_r[i]  <= 1'b0;
      end
      state_r      <= otp_pkg::BK_IDLE;
      scan_idx_r   <= '0;
      pend_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      slot_st_r    <= slot_st_nxt;
      ticks_r      <= ticks_nxt;
      tag_r        <= tag_nxt;
      notify_r     <= notify_nxt;
      state_r      <= state_nxt;
      scan_idx_r   <= scan_idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_slot_r <= pend_slot_nxt;
    pend_tag_r  <= pend_tag_nxt;
    res_r       <= res_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (state_r != otp_pkg::BK_IDLE))
    else $error("held expiry outside a tick scan");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == otp_pkg::BK_IDLE && res_free))
    else $error("command taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == otp_pkg::BK_SCAN && scan_fire && pend_valid_r && res_free) |=>
      (res_valid_r && !res_r.last && res_r.status == otp_pkg::STS_EXPIRED))
    else $error("mid-scan expiry not flushed correctly");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == otp_pkg::BK_FINISH && res_free) |=>
      (res_valid_r && res_r.last && state_r == otp_pkg::BK_IDLE))
    else $error("tick did not close with a last item");

endmodule

// ===== hdl/one_shot_timer_pool.sv =====
// one_shot_timer_pool: top level of the one-shot countdown timer pool
// depends on otp_pkg, otp_front, otp_cmd_fifo and otp_back
//
//   channel   dir  handshake             payload
//   in_       in   in_tvalid/in_tready   in_tuser: func; in_tdata: index, count, tag, notify
//   out_      out  out_tvalid/out_tready out_tuser: status; out_tdata: slot, tag; out_tlast
//
// allocate, free, set count and set tag are carried out in the back end once
// they reach the head of the queue; a tick scans the slot table one slot per
// cycle, pausing while a second expiry waits on a full result register
// reset (rst_n low, synchronous) frees every slot and empties queue and results
// the two-entry command queue keeps accepting items until full while a result waits on
// out_tready; the back end pauses on a full result register
module one_shot_timer_pool (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] func
  input  logic [otp_pkg::FUNC_W-1:0]      in_tuser,
  // [2:0] timer_index, [34:3] count_value, [66:35] tag_value,
  // [67] notify_enable, [71:68] zero
  input  logic [otp_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [2:0] status
  output logic [otp_pkg::STATUS_W-1:0]    out_tuser,
  // [2:0] slot, [34:3] expired_tag, [39:35] zero
  output logic [otp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);

  otp_pkg::cmd_t front_cmd;
  otp_pkg::cmd_t head_cmd;
  otp_pkg::res_t res;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic          q_push;

  // front end: decode and queue
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  otp_front u_front (
    .func  (in_tuser),
    .tdata (in_tdata),
    .cmd   (front_cmd)
  );

  otp_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (head_cmd),
    .empty     (q_empty)
  );

  // back end: slot table, tick scan and result register
  otp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (head_cmd),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  // pack the result item
  assign out_tuser = res.status;
  assign out_tdata = {(otp_pkg::OUT_TDATA_W - otp_pkg::TAG_W - otp_pkg::SLOT_W)'(0),
                      res.tag, res.slot};
  assign out_tlast = res.last;

endmodule
